// ===== hw/rtl/qed_pkg.sv =====
// shared types, register codes and decode tables of the quadrature encoder decoder
package qed_pkg;

	localparam int POS_W      = 16;
	localparam int LIMIT_W    = 16;
	localparam int HOLD_W     = 16;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_FOUR_X_MODE   = 3'd0;
	localparam cfg_idx_t REG_HOLD_TIME_CW  = 3'd1;
	localparam cfg_idx_t REG_HOLD_TIME_CCW = 3'd2;
	localparam cfg_idx_t REG_COUNT_MIN     = 3'd3;
	localparam cfg_idx_t REG_COUNT_MAX     = 3'd4;

	typedef logic signed [1:0] step_t;

	localparam step_t STEP_NONE = 2'sd0;
	localparam step_t STEP_CW   = 2'sd1;
	localparam step_t STEP_CCW  = -2'sd1;

	typedef struct packed {
		logic                      four_x_mode;
		logic [HOLD_W-1:0]         hold_time_cw;
		logic [HOLD_W-1:0]         hold_time_ccw;
		logic signed [LIMIT_W-1:0] count_min;
		logic signed [LIMIT_W-1:0] count_max;
	} cfg_t;

	localparam logic [HOLD_W-1:0]         HOLD_RESET = 16'd50;
	localparam logic signed [LIMIT_W-1:0] MIN_RESET  = -16'sd32767;
	localparam logic signed [LIMIT_W-1:0] MAX_RESET  = 16'sd32767;

	typedef struct packed {
		logic                 cw_held;
		logic                 ccw_held;
		logic [POS_W-1:0]     position;
	} track_t;

	// full-cycle detent tracker, one-hot
	typedef enum logic [5:0] {
		ST_REST  = 6'b000001,
		ST_MID   = 6'b000010,
		ST_CW_A  = 6'b000100,
		ST_CCW_A = 6'b001000,
		ST_CW_B  = 6'b010000,
		ST_CCW_B = 6'b100000
	} cycle_state_t;

	typedef struct packed {
		cycle_state_t nxt;
		step_t        dir;
	} cycle_out_t;

	// ab code is {line_b, line_a}
	function automatic cycle_out_t cycle_next(cycle_state_t st, logic [1:0] ab);
		cycle_out_t r;
		r.dir = STEP_NONE;
		r.nxt = ST_REST;
		if (ab == 2'd0) begin
			r.nxt = ST_MID;
		end else begin
			unique case (st)
				ST_MID: begin
					case (ab)
						2'd1:    r.nxt = ST_CCW_B;
						2'd2:    r.nxt = ST_CW_B;
						default: r.nxt = ST_REST;
					endcase
				end
				ST_CW_A: begin
					r.nxt = (ab == 2'd1) ? ST_CW_A : ST_REST;
				end
				ST_CCW_A: begin
					r.nxt = (ab == 2'd2) ? ST_CCW_A : ST_REST;
				end
				ST_CW_B: begin
					case (ab)
						2'd2: r.nxt = ST_CW_B;
						2'd3: begin
							r.nxt = ST_REST;
							r.dir = STEP_CW;
						end
						default: r.nxt = ST_REST;
					endcase
				end
				ST_CCW_B: begin
					case (ab)
						2'd1: r.nxt = ST_CCW_B;
						2'd3: begin
							r.nxt = ST_REST;
							r.dir = STEP_CCW;
						end
						default: r.nxt = ST_REST;
					endcase
				end
				default: begin
					case (ab)
						2'd1:    r.nxt = ST_CW_A;
						2'd2:    r.nxt = ST_CCW_A;
						default: r.nxt = ST_REST;
					endcase
				end
			endcase
		end
		return r;
	endfunction

	// 4x table indexed by {previous ab, current ab}
	localparam step_t EDGE_STEP [16] = '{
		STEP_NONE, STEP_CW,   STEP_CCW,  STEP_NONE,
		STEP_CCW,  STEP_NONE, STEP_NONE, STEP_CW,
		STEP_CW,   STEP_NONE, STEP_NONE, STEP_CCW,
		STEP_NONE, STEP_CCW,  STEP_CW,   STEP_NONE
	};

endpackage

// ===== hw/rtl/qed_poll_if.sv =====
// poll channel: encoder line levels and time stamp
interface qed_poll_if;
	logic                         valid;
	logic                         ready;
	logic                         line_a;
	logic                         line_b;
	logic [qed_pkg::TIME_W-1:0]   now_ms;

	modport source (output valid, output line_a, output line_b, output now_ms, input ready);
	modport sink (input valid, input line_a, input line_b, input now_ms, output ready);
endinterface

// ===== hw/rtl/qed_result_if.sv =====
// result channel: step, held outputs and position
interface qed_result_if;
	logic                         valid;
	logic                         ready;
	qed_pkg::step_t               step;
	logic                         cw_held;
	logic                         ccw_held;
	logic signed [qed_pkg::POS_W-1:0] position;

	modport source (output valid, output step, output cw_held, output ccw_held,
		output position, input ready);
	modport sink (input valid, input step, input cw_held, input ccw_held,
		input position, output ready);
endinterface

// ===== hw/rtl/qed_cfg_if.sv =====
// configuration write channel
interface qed_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [qed_pkg::CFG_IDX_W-1:0]    index;
	logic [qed_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/quadrature_encoder_decoder.sv =====
// quadrature encoder decoder top level
//
//   channel  dir  payload                                    handshake
//   poll     in   line_a, line_b, now_ms                     valid / ready
//   result   out  step, cw_held, ccw_held, position           valid / ready
//   cfg      in   index (3 b), data (16 b)                   valid / ready, always ready
//
// one poll per clock sustained while results are taken; a request passes through the input register
// and then the result register, which drives the result channel.
// the decode state and position move as a poll leaves the input register.
// arst_n clears state, counter and the valid bits of both registers; config returns to its reset values.
// a stalled result holds the input register, and poll.ready drops only when both are full.
module quadrature_encoder_decoder #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	qed_poll_if.sink      poll,
	qed_result_if.source  result,
	qed_cfg_if.sink       cfg
);

	logic                          valid_s1;
	logic                          line_a_s1;
	logic                          line_b_s1;
	logic [qed_pkg::TIME_W-1:0]    now_ms_s1;
	logic                          valid_s2;
	qed_pkg::step_t                step_s2;
	qed_pkg::track_t               trk_s2;

	logic                          advance;
	qed_pkg::cfg_t                 regs;
	qed_pkg::step_t                dir;
	qed_pkg::track_t               trk;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign poll.ready = !valid_s1 || advance;

	qed_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	qed_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.four_x_mode (regs.four_x_mode),
		.line_a      (line_a_s1),
		.line_b      (line_b_s1),
		.dir         (dir)
	);

	qed_track #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.dir     (dir),
		.now_ms  (now_ms_s1),
		.regs    (regs),
		.trk     (trk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			line_a_s1 <= poll.line_a;
			line_b_s1 <= poll.line_b;
			now_ms_s1 <= poll.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			step_s2 <= dir;
			trk_s2  <= trk;
		end
	end

	assign result.valid    = valid_s2;
	assign result.step     = step_s2;
	assign result.cw_held  = trk_s2.cw_held;
	assign result.ccw_held = trk_s2.ccw_held;
	assign result.position = $signed(trk_s2.position);

endmodule

// ===== hw/rtl/qed_cfg_regs.sv =====
// configuration register file
module qed_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	qed_cfg_if.sink        cfg,
	output qed_pkg::cfg_t  regs
);

	qed_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.four_x_mode   <= 1'b0;
			regs_q.hold_time_cw  <= qed_pkg::HOLD_RESET;
			regs_q.hold_time_ccw <= qed_pkg::HOLD_RESET;
			regs_q.count_min     <= qed_pkg::MIN_RESET;
			regs_q.count_max     <= qed_pkg::MAX_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				qed_pkg::REG_FOUR_X_MODE:   regs_q.four_x_mode   <= cfg.data[0];
				qed_pkg::REG_HOLD_TIME_CW:  regs_q.hold_time_cw  <= cfg.data;
				qed_pkg::REG_HOLD_TIME_CCW: regs_q.hold_time_ccw <= cfg.data;
				qed_pkg::REG_COUNT_MIN:     regs_q.count_min     <= $signed(cfg.data);
				qed_pkg::REG_COUNT_MAX:     regs_q.count_max     <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/qed_decode.sv =====
// line decoder: full-cycle detent machine and 4x edge history
module qed_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            four_x_mode,
	input  logic            line_a,
	input  logic            line_b,
	output qed_pkg::step_t  dir
);

	qed_pkg::cycle_state_t state_q;
	logic [3:0]            hist_q;
	logic [1:0]            ab;
	logic [3:0]            hist_d;
	qed_pkg::cycle_out_t   cyc;

	assign ab     = {line_b, line_a};
	assign hist_d = {hist_q[1:0], ab};
	assign cyc    = qed_pkg::cycle_next(state_q, ab);
	assign dir    = four_x_mode ? qed_pkg::EDGE_STEP[hist_d] : cyc.dir;

	// only the mode in use moves its own state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qed_pkg::ST_REST;
			hist_q  <= 4'd0;
		end else if (advance) begin
			if (four_x_mode) begin
				hist_q <= hist_d;
			end else begin
				state_q <= cyc.nxt;
			end
		end
	end

endmodule

// ===== hw/rtl/qed_track.sv =====
// saturating position counter and held direction outputs
module qed_track #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  qed_pkg::step_t                dir,
	input  logic [qed_pkg::TIME_W-1:0]    now_ms,
	input  qed_pkg::cfg_t                 regs,
	output qed_pkg::track_t               trk
);

	localparam int XW = ((COUNT_WIDTH > qed_pkg::LIMIT_W) ? COUNT_WIDTH : qed_pkg::LIMIT_W) + 2;
	localparam logic signed [XW-1:0] HI = XW'((64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1);
	localparam logic signed [XW-1:0] LO = -HI - XW'(1);

	logic signed [COUNT_WIDTH-1:0] pos_q;
	logic [qed_pkg::TIME_W-1:0]    last_q;
	logic                          cw_q;
	logic                          ccw_q;

	logic signed [XW-1:0]          sum;
	logic signed [XW-1:0]          c_hi;
	logic signed [XW-1:0]          c_lo;
	logic signed [XW-1:0]          c_max;
	logic signed [XW-1:0]          c_min;
	logic signed [XW-1:0]          min_x;
	logic signed [XW-1:0]          max_x;
	logic signed [XW-1:0]          pos_x;
	logic signed [COUNT_WIDTH-1:0] pos_d;
	logic [qed_pkg::TIME_W-1:0]    last_d;
	logic [qed_pkg::TIME_W-1:0]    elapsed;
	logic                          stepped;
	logic                          cw_d;
	logic                          ccw_d;

	assign stepped = (dir != qed_pkg::STEP_NONE);
	assign min_x   = XW'(regs.count_min);
	assign max_x   = XW'(regs.count_max);
	assign sum     = XW'(pos_q) + XW'(dir);

	// word range first, then the configured limits, minimum last
	always_comb begin
		c_hi  = (sum > HI) ? HI : sum;
		c_lo  = (c_hi < LO) ? LO : c_hi;
		c_max = (c_lo > max_x) ? max_x : c_lo;
		c_min = (c_max < min_x) ? min_x : c_max;
	end

	assign pos_d   = stepped ? c_min[COUNT_WIDTH-1:0] : pos_q;
	assign last_d  = stepped ? now_ms : last_q;
	assign elapsed = now_ms - last_d;
	assign cw_d    = (cw_q || dir == qed_pkg::STEP_CW) &&
		!(elapsed > qed_pkg::TIME_W'(regs.hold_time_cw));
	assign ccw_d   = (ccw_q || dir == qed_pkg::STEP_CCW) &&
		!(elapsed > qed_pkg::TIME_W'(regs.hold_time_ccw));

	assign pos_x        = XW'(pos_d);
	assign trk.position = pos_x[qed_pkg::POS_W-1:0];
	assign trk.cw_held  = cw_d;
	assign trk.ccw_held = ccw_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			last_q <= '0;
			cw_q   <= 1'b0;
			ccw_q  <= 1'b0;
		end else if (advance) begin
			pos_q  <= pos_d;
			last_q <= last_d;
			cw_q   <= cw_d;
			ccw_q  <= ccw_d;
		end
	end

endmodule

// ===== hw/rtl/qed_checker.sv =====
// port checker for the quadrature encoder decoder, bound to the top level
module qed_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  qed_pkg::step_t                res_step,
	input  logic                          res_cw_held,
	input  logic                          res_ccw_held,
	input  logic [qed_pkg::POS_W-1:0]     res_position
);

	// step is one of the three legal codes
	a_step_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_step == qed_pkg::STEP_NONE || res_step == qed_pkg::STEP_CW ||
			res_step == qed_pkg::STEP_CCW))
		else $error("illegal step code");

	// a stepping poll keeps its own direction held
	a_cw_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_step == qed_pkg::STEP_CW) |-> res_cw_held)
		else $error("clockwise step without held output");

	a_ccw_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_step == qed_pkg::STEP_CCW) |-> res_ccw_held)
		else $error("counter-clockwise step without held output");

	// stalled result keeps its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_step) &&
			$stable(res_position) && $stable(res_cw_held) && $stable(res_ccw_held)))
		else $error("result changed while stalled");

endmodule

bind quadrature_encoder_decoder qed_checker u_qed_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_step     (result.step),
	.res_cw_held  (result.cw_held),
	.res_ccw_held (result.ccw_held),
	.res_position (result.position)
);

// ===== tb/quadrature_encoder_decoder_test.sv =====
`timescale 1ns / 1ps
// self-checking test of the quadrature encoder decoder: directed table, then random encoder walks
module quadrature_encoder_decoder_test;
	import qed_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int RESET_CYCLES    = 4;
	localparam int PHASES          = 8;
	localparam int PHASE_ITEMS     = 125;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int SETTLE_CYCLES   = 3;
	localparam int DRAIN_LIMIT     = 5000;
	localparam int DRAIN_TAIL      = 8;
	localparam int TIMEOUT_NS      = 4_000_000;

	localparam cfg_idx_t REG_SPARE_LO = cfg_idx_t'(REG_COUNT_MAX + 1);
	localparam cfg_idx_t REG_SPARE_HI = {CFG_IDX_W{1'b1}};

	typedef struct packed {
		step_t            step;
		logic             cw;
		logic             ccw;
		logic [POS_W-1:0] pos;
	} poll_result_t;

	typedef enum bit [1:0] {ROW_SET, ROW_POLL, ROW_KNOWN} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		cfg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  a;
		logic                  b;
		logic [TIME_W-1:0]     t;
		poll_result_t          want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	qed_poll_if   poll_ch ();
	qed_result_if result_ch ();
	qed_cfg_if    cfg_ch ();

	quadrature_encoder_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// decoder model state and register copy
	cfg_t                    cur_cfg = '{1'b0, HOLD_RESET, HOLD_RESET, MIN_RESET, MAX_RESET};
	cycle_state_t            fc_state = ST_REST;
	logic [3:0]              edge_hist = '0;
	logic signed [POS_W-1:0] pos_count = '0;
	logic [TIME_W-1:0]       last_step_ms = '0;
	logic                    cw_on = 1'b0;
	logic                    ccw_on = 1'b0;

	poll_result_t pending_readings[$];
	poll_result_t want_r;
	stim_row_t    stim_rows[$];
	int           mismatches = 0;
	bit           quiet = 1'b0;
	bit           rx_hold_off = 1'b0;
	logic [1:0]   walk_ab = 2'b11;
	bit           walk_cw = 1'b1;
	logic [TIME_W-1:0] clock_ms = '0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

	// full-cycle detent machine, one step per complete cycle back to rest
	function automatic step_t cycle_turn(input logic [1:0] ab);
		step_t dir;
		dir = STEP_NONE;
		if (ab == 2'd0) begin
			fc_state = ST_MID;
		end else begin
			case (fc_state)
				ST_MID: begin
					fc_state = (ab == 2'd1) ? ST_CCW_B : (ab == 2'd2) ? ST_CW_B : ST_REST;
				end
				ST_CW_A: begin
					fc_state = (ab == 2'd1) ? ST_CW_A : ST_REST;
				end
				ST_CCW_A: begin
					fc_state = (ab == 2'd2) ? ST_CCW_A : ST_REST;
				end
				ST_CW_B: begin
					fc_state = (ab == 2'd2) ? ST_CW_B : ST_REST;
					if (ab == 2'd3)
						dir = STEP_CW;
				end
				ST_CCW_B: begin
					fc_state = (ab == 2'd1) ? ST_CCW_B : ST_REST;
					if (ab == 2'd3)
						dir = STEP_CCW;
				end
				default: begin
					fc_state = (ab == 2'd1) ? ST_CW_A : (ab == 2'd2) ? ST_CCW_A : ST_REST;
				end
			endcase
		end
		return dir;
	endfunction

	function automatic poll_result_t decode_poll(input logic a, input logic b,
			input logic [TIME_W-1:0] now);
		logic [1:0]        ab;
		logic [1:0]        prev;
		logic [1:0]        rank_diff;
		step_t             dir;
		int                n;
		int                lo;
		int                hi;
		logic [TIME_W-1:0] elapsed;
		poll_result_t      res;
		ab = {b, a};
		dir = STEP_NONE;
		if (cur_cfg.four_x_mode) begin
			prev = edge_hist[1:0];
			edge_hist = {prev, ab};
			// position along the gray cycle 00, 01, 11, 10
			rank_diff = {ab[1], ^ab} - {prev[1], ^prev};
			if (rank_diff == 2'd1)
				dir = STEP_CW;
			else if (rank_diff == 2'd3)
				dir = STEP_CCW;
		end else begin
			dir = cycle_turn(ab);
		end
		if (dir != STEP_NONE) begin
			lo = -(1 << (POS_W - 1));
			hi = (1 << (POS_W - 1)) - 1;
			n = $signed(pos_count) + $signed(dir);
			if (n > hi) n = hi;
			if (n < lo) n = lo;
			if (n > $signed(cur_cfg.count_max)) n = $signed(cur_cfg.count_max);
			if (n < $signed(cur_cfg.count_min)) n = $signed(cur_cfg.count_min);
			pos_count = n[POS_W-1:0];
			if (dir == STEP_CW)
				cw_on = 1'b1;
			else
				ccw_on = 1'b1;
			last_step_ms = now;
		end
		elapsed = now - last_step_ms;
		if (elapsed > TIME_W'(cur_cfg.hold_time_cw)) cw_on = 1'b0;
		if (elapsed > TIME_W'(cur_cfg.hold_time_ccw)) ccw_on = 1'b0;
		res.step = dir;
		res.cw = cw_on;
		res.ccw = ccw_on;
		res.pos = pos_count;
		return res;
	endfunction

	function automatic logic [HOLD_W-1:0] pick_hold(input int k);
		case (k % 3)
			0:       return '0;
			1:       return '1;
			default: return HOLD_W'($urandom_range(1, 30));
		endcase
	endfunction

	task automatic tab_set(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r = '{kind: ROW_SET, idx: idx, data: data, a: 1'b1, b: 1'b1, t: '0, want: '0};
		stim_rows.push_back(r);
	endtask

	task automatic tab_poll(input logic a, input logic b, input logic [TIME_W-1:0] t);
		stim_row_t r;
		r = '{kind: ROW_POLL, idx: REG_FOUR_X_MODE, data: '0, a: a, b: b, t: t, want: '0};
		stim_rows.push_back(r);
	endtask

	task automatic tab_known(input logic a, input logic b, input logic [TIME_W-1:0] t,
			input step_t s, input logic cw, input logic ccw, input logic [POS_W-1:0] p);
		stim_row_t r;
		r = '{kind: ROW_KNOWN, idx: REG_FOUR_X_MODE, data: '0, a: a, b: b, t: t,
			want: '{step: s, cw: cw, ccw: ccw, pos: p}};
		stim_rows.push_back(r);
	endtask

	task automatic send_poll(input logic a, input logic b, input logic [TIME_W-1:0] t,
			input bit known, input poll_result_t typed);
		poll_result_t guess;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			poll_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.line_a <= a;
		poll_ch.line_b <= b;
		poll_ch.now_ms <= t;
		@(posedge clk);
		while (!poll_ch.ready) @(posedge clk);
		guess = decode_poll(a, b, t);
		pending_readings.push_back(known ? typed : guess);
	endtask

	task automatic write_setting(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FOUR_X_MODE:   cur_cfg.four_x_mode = data[0];
			REG_HOLD_TIME_CW:  cur_cfg.hold_time_cw = data;
			REG_HOLD_TIME_CCW: cur_cfg.hold_time_ccw = data;
			REG_COUNT_MIN:     cur_cfg.count_min = data;
			REG_COUNT_MAX:     cur_cfg.count_max = data;
			default: ;
		endcase
	endtask

	// wait for every outstanding request to come back before touching registers
	task automatic settle();
		poll_ch.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int p);
		logic [CFG_DATA_W-1:0]     mode_word;
		logic signed [LIMIT_W-1:0] lo_lim;
		logic signed [LIMIT_W-1:0] hi_lim;
		logic [1:0]                rank;
		int                        r;
		settle();
		mode_word = CFG_DATA_W'($urandom);
		mode_word[0] = p[0];
		write_setting(REG_FOUR_X_MODE, mode_word);
		write_setting(REG_HOLD_TIME_CW, pick_hold(p));
		write_setting(REG_HOLD_TIME_CCW, pick_hold(p + 1));
		case (p % 5)
			0: begin
				lo_lim = MIN_RESET;
				hi_lim = MAX_RESET;
			end
			1: begin
				lo_lim = {1'b1, {(LIMIT_W-1){1'b0}}};
				hi_lim = {1'b0, {(LIMIT_W-1){1'b1}}};
			end
			2: begin
				lo_lim = -LIMIT_W'($urandom_range(0, 4));
				hi_lim = LIMIT_W'($urandom_range(0, 4));
			end
			3: begin
				// crossed limits, the minimum limit wins
				lo_lim = LIMIT_W'($urandom_range(1, 4));
				hi_lim = -LIMIT_W'($urandom_range(1, 4));
			end
			default: begin
				lo_lim = LIMIT_W'($urandom);
				hi_lim = LIMIT_W'($urandom);
			end
		endcase
		write_setting(REG_COUNT_MIN, lo_lim);
		write_setting(REG_COUNT_MAX, hi_lim);
		if (p == 3)
			write_setting(cfg_idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
				CFG_DATA_W'($urandom));
		quiet = (p == PHASES - 1);
		if (p == 1)
			rx_hold_off = 1'b1;
		repeat (PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				if ($urandom_range(0, 9) == 0)
					walk_cw = !walk_cw;
				rank = {walk_ab[1], ^walk_ab} + (walk_cw ? 2'd1 : 2'd3);
				walk_ab = {rank[1], ^rank};
			end else if (r >= 90) begin
				walk_ab = 2'($urandom);
			end
			r = $urandom_range(0, 99);
			if (r < 70)
				clock_ms = clock_ms + $urandom_range(0, 3);
			else if (r < 90)
				clock_ms = clock_ms + $urandom_range(0, 40);
			else if (r < 98)
				clock_ms = clock_ms + $urandom_range(0, 70000);
			else
				clock_ms = $urandom;
			send_poll(walk_ab[0], walk_ab[1], clock_ms, 1'b0, '0);
		end
	endtask

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (rx_hold_off) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				rx_hold_off = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected result: step %0d cw %0b ccw %0b position %0d", $time,
					result_ch.step, result_ch.cw_held, result_ch.ccw_held,
					result_ch.position);
				mismatches++;
			end else begin
				want_r = pending_readings.pop_front();
				if (result_ch.step !== want_r.step || result_ch.cw_held !== want_r.cw ||
						result_ch.ccw_held !== want_r.ccw ||
						result_ch.position !== want_r.pos) begin
					$display("%0t: mismatch: expected step %0d cw %0b ccw %0b position %0d, got step %0d cw %0b ccw %0b position %0d",
						$time, want_r.step, want_r.cw, want_r.ccw, $signed(want_r.pos),
						result_ch.step, result_ch.cw_held, result_ch.ccw_held,
						result_ch.position);
					mismatches++;
				end
			end
		end
	end

	initial begin
		poll_ch.valid = 1'b0;
		poll_ch.line_a = 1'b1;
		poll_ch.line_b = 1'b1;
		poll_ch.now_ms = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_FOUR_X_MODE;
		cfg_ch.data = '0;
		arst_n = 1'b0;

		// full-cycle mode from reset: one clockwise and one counter-clockwise detent
		tab_known(1'b1, 1'b1, 0, STEP_NONE, 1'b0, 1'b0, 16'sd0);
		tab_poll(1'b1, 1'b0, 1);
		tab_poll(1'b0, 1'b0, 2);
		tab_poll(1'b0, 1'b1, 3);
		tab_known(1'b1, 1'b1, 4, STEP_CW, 1'b1, 1'b0, 16'sd1);
		tab_known(1'b1, 1'b1, 55, STEP_NONE, 1'b0, 1'b0, 16'sd1);
		tab_poll(1'b0, 1'b1, 100);
		tab_poll(1'b0, 1'b0, 101);
		tab_poll(1'b1, 1'b0, 102);
		tab_known(1'b1, 1'b1, 103, STEP_CCW, 1'b0, 1'b1, 16'sd0);
		// bounce back to rest, then time jumping to its maximum value
		tab_poll(1'b1, 1'b0, 104);
		tab_poll(1'b1, 1'b1, 105);
		tab_known(1'b1, 1'b1, '1, STEP_NONE, 1'b0, 1'b0, 16'sd0);
		// 4x mode against the counter extremes
		tab_set(REG_FOUR_X_MODE, '1);
		tab_set(REG_COUNT_MIN, 16'h7fff);
		tab_set(REG_COUNT_MAX, 16'h7fff);
		tab_poll(1'b1, 1'b1, 0);
		tab_known(1'b1, 1'b0, 1, STEP_CCW, 1'b0, 1'b1, 16'h7fff);
		tab_set(REG_COUNT_MIN, 16'h8000);
		tab_known(1'b1, 1'b1, 2, STEP_CW, 1'b1, 1'b1, 16'h7fff);
		tab_set(REG_COUNT_MAX, 16'h8000);
		tab_known(1'b1, 1'b0, 3, STEP_CCW, 1'b1, 1'b1, 16'h8000);
		tab_set(REG_COUNT_MAX, 16'h7fff);
		tab_known(1'b0, 1'b0, 4, STEP_CCW, 1'b1, 1'b1, 16'h8000);
		tab_set(REG_HOLD_TIME_CW, 16'd0);
		tab_set(REG_HOLD_TIME_CCW, 16'hffff);
		tab_known(1'b0, 1'b0, 5, STEP_NONE, 1'b0, 1'b1, 16'h8000);
		tab_poll(1'b1, 1'b1, 6);
		// hold released only once strictly past the hold time
		tab_set(REG_HOLD_TIME_CW, 16'd10);
		tab_poll(1'b0, 1'b1, 100);
		tab_poll(1'b0, 1'b1, 110);
		tab_poll(1'b0, 1'b1, 111);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_SET) begin
				settle();
				write_setting(stim_rows[i].idx, stim_rows[i].data);
			end else begin
				send_poll(stim_rows[i].a, stim_rows[i].b, stim_rows[i].t,
					stim_rows[i].kind == ROW_KNOWN, stim_rows[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++)
			run_phase(p);

		poll_ch.valid <= 1'b0;
		for (int w = 0; w < DRAIN_LIMIT && pending_readings.size() != 0; w++)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (pending_readings.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_readings.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
